[src/mhu_pkg.sv]
package mhu_pkg;

    // Default number of fraction bits on the heading output
    localparam int HFB_DEFAULT   = 6;

    // Axis value the sensor reports on overflow
    localparam logic signed [15:0] OVF_MARK = -16'sd4096;

    // CORDIC datapath
    localparam int CORDIC_ITERS  = 61;
    localparam int CORDIC_W      = 64;
    localparam int PRESCALE      = 44;
    // angle accumulator is Q60 in units of 45 degrees
    localparam int ZFRAC         = 60;

    // Per-sample sideband that rides along the CORDIC pipeline
    typedef struct packed {
        logic               ok_res;   // transfer ok and no overflow
        logic               zero;     // both x and y are zero
        logic               swap;     // |y| > |x|, angle taken from 90
        logic               x_neg;
        logic               y_neg;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_side;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        t_side                      side;
    } t_cordic;

    // atan(2^-idx) in Q60 units of 45 degrees, evaluated at elaboration.
    // pi/4 from Machin's formula, atan(2^-i) from its power series,
    // then a 62-step long division gives the ratio.
    function automatic logic [63:0] mhu_eighth(input int idx);
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] s5;
        logic [63:0] s239;
        logic [63:0] quarter;
        logic [63:0] sum;
        logic [63:0] rem;
        logic [63:0] q;
        int          k;
        int          e;
        logic        done;
        // atan(1/5)
        s5 = '0;
        p  = (64'd1 << 62) / 64'd5;
        for (k = 0; k < 40; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if (k[0]) s5 = s5 - t;
                else      s5 = s5 + t;
                p = p / 64'd25;
            end
        end
        // atan(1/239)
        s239 = '0;
        p    = (64'd1 << 62) / 64'd239;
        for (k = 0; k < 40; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if (k[0]) s239 = s239 - t;
                else      s239 = s239 + t;
                p = p / 64'd57121;
            end
        end
        quarter = (s5 << 2) - s239;
        if (idx == 0) begin
            return 64'd1 << ZFRAC;
        end
        // atan(2^-idx) in Q62
        sum  = '0;
        done = 1'b0;
        for (k = 0; k < 32; k++) begin
            if (!done) begin
                e = idx * (2 * k + 1);
                if (e > 62) begin
                    done = 1'b1;
                end else begin
                    t = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                    if (k[0]) sum = sum - t;
                    else      sum = sum + t;
                end
            end
        end
        // divide by pi/4
        rem = sum;
        q   = '0;
        for (k = 0; k < 62; k++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= quarter) begin
                rem  = rem - quarter;
                q[0] = 1'b1;
            end
        end
        return q >> 2;
    endfunction

endpackage

[src/magnetometer_heading_unit.sv]
// Compass heading from one magnetometer read. Each word carries the six axis
// bytes (X, Z, Y, MSB first) and a transfer-ok flag; the result word carries the
// three signed axes, a valid flag (transfer ok and no axis at the -4096
// overflow marker) and the heading atan2(y, x) in degrees over [0, 360), with
// HEADING_FRAC_BITS fraction bits, rounded to nearest (0 when not valid or when
// x and y are both zero). One word is taken every cycle unless the result side
// stalls. Axis assembly and octant folding fill the front register, the 61-stage
// vectoring CORDIC pipeline does one micro-rotation per stage, and stages M, R and
// Q do scaling, rounding and quadrant mapping, ending in the output register. Each
// stage moves independently, so bubbles close up and input is taken while a
// finished word waits at the output.
module magnetometer_heading_unit import mhu_pkg::*; #(
    parameter int HEADING_FRAC_BITS = HFB_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_transfer_ok,
    input  logic [7:0]                   i_x_high,
    input  logic [7:0]                   i_x_low,
    input  logic [7:0]                   i_z_high,
    input  logic [7:0]                   i_z_low,
    input  logic [7:0]                   i_y_high,
    input  logic [7:0]                   i_y_low,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [HEADING_FRAC_BITS+8:0] o_heading,
    output logic signed [15:0]           o_axis_x,
    output logic signed [15:0]           o_axis_y,
    output logic signed [15:0]           o_axis_z,
    output logic                         o_valid_res
);

    logic    front_en, front_v;
    logic    cordic_en, cordic_v;
    logic    back_en;
    t_cordic front_d, cordic_d;

    mhu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_transfer_ok (i_transfer_ok),
        .i_x_high      (i_x_high),
        .i_x_low       (i_x_low),
        .i_z_high      (i_z_high),
        .i_z_low       (i_z_low),
        .i_y_high      (i_y_high),
        .i_y_low       (i_y_low),
        .i_next_en     (cordic_en),
        .o_en          (front_en),
        .o_v           (front_v),
        .o_d           (front_d)
    );

    mhu_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_v       (front_v),
        .i_d       (front_d),
        .i_next_en (back_en),
        .o_en      (cordic_en),
        .o_v       (cordic_v),
        .o_d       (cordic_d)
    );

    mhu_back #(
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_v         (cordic_v),
        .i_d         (cordic_d),
        .o_en        (back_en),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_heading   (o_heading),
        .o_axis_x    (o_axis_x),
        .o_axis_y    (o_axis_y),
        .o_axis_z    (o_axis_z),
        .o_valid_res (o_valid_res)
    );

    assign o_stall = !front_en;

endmodule

[src/mhu_front.sv]
module mhu_front import mhu_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_transfer_ok,
    input  logic [7:0]    i_x_high,
    input  logic [7:0]    i_x_low,
    input  logic [7:0]    i_z_high,
    input  logic [7:0]    i_z_low,
    input  logic [7:0]    i_y_high,
    input  logic [7:0]    i_y_low,
    input  logic          i_next_en,
    output logic          o_en,
    output logic          o_v,
    output t_cordic       o_d
);

    logic signed [15:0] x, y, z;
    logic        [16:0] ax, ay, d, n;
    logic               ovf;
    logic               en;
    t_cordic            n_d;
    t_cordic            r_d;
    logic               r_v;

    // assemble axes, MSB first
    assign x = signed'({i_x_high, i_x_low});
    assign y = signed'({i_y_high, i_y_low});
    assign z = signed'({i_z_high, i_z_low});

    assign ovf = (x == OVF_MARK) || (y == OVF_MARK) || (z == OVF_MARK);

    // magnitudes, 17 bits so that -32768 fits
    assign ax = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    assign ay = y[15] ? (17'd0 - {y[15], y}) : {1'b0, y};

    // fold into the first octant: n <= d
    always_comb begin
        n_d = '0;
        n_d.side.swap = (ay > ax);
        d = n_d.side.swap ? ay : ax;
        n = n_d.side.swap ? ax : ay;
        n_d.x = signed'({3'b000, d, {PRESCALE{1'b0}}});
        n_d.y = signed'({3'b000, n, {PRESCALE{1'b0}}});
        n_d.z = '0;
        n_d.side.ok_res = i_transfer_ok && !ovf;
        n_d.side.zero   = (x == 16'sd0) && (y == 16'sd0);
        n_d.side.x_neg  = x[15];
        n_d.side.y_neg  = y[15];
        n_d.side.axis_x = i_transfer_ok ? x : 16'sd0;
        n_d.side.axis_y = i_transfer_ok ? y : 16'sd0;
        n_d.side.axis_z = i_transfer_ok ? z : 16'sd0;
    end

    // stage moves when empty or when downstream takes its word
    assign en = !r_v || i_next_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d <= n_d;
        end
    end

    assign o_en = en;
    assign o_v  = r_v;
    assign o_d  = r_d;

endmodule

[src/mhu_cordic_stage.sv]
module mhu_cordic_stage import mhu_pkg::*; #(
    parameter int ITER = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_v,
    input  t_cordic i_d,
    input  logic    i_next_en,
    output logic    o_en,
    output logic    o_v,
    output t_cordic o_d
);

    localparam logic signed [CORDIC_W-1:0] ATAN_STEP = signed'(mhu_eighth(ITER));

    logic signed [CORDIC_W-1:0] x, y, z, xs, ys;
    t_cordic                    n_d;
    t_cordic                    r_d;
    logic                       r_v;
    logic                       en;

    assign x  = i_d.x;
    assign y  = i_d.y;
    assign z  = i_d.z;
    assign xs = x >>> ITER;
    assign ys = y >>> ITER;

    // one vectoring micro-rotation, driving y toward zero
    always_comb begin
        n_d      = i_d;
        if (!y[CORDIC_W-1]) begin
            n_d.x = x + ys;
            n_d.y = y - xs;
            n_d.z = z + ATAN_STEP;
        end else begin
            n_d.x = x - ys;
            n_d.y = y + xs;
            n_d.z = z - ATAN_STEP;
        end
    end

    assign en = !r_v || i_next_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d <= n_d;
        end
    end

    assign o_en = en;
    assign o_v  = r_v;
    assign o_d  = r_d;

endmodule

[src/mhu_cordic.sv]
module mhu_cordic import mhu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_v,
    input  t_cordic i_d,
    input  logic    i_next_en,
    output logic    o_en,
    output logic    o_v,
    output t_cordic o_d
);

    t_cordic s_d  [0:CORDIC_ITERS];
    logic    s_v  [0:CORDIC_ITERS];
    logic    s_en [0:CORDIC_ITERS];

    assign s_d[0]             = i_d;
    assign s_v[0]             = i_v;
    assign s_en[CORDIC_ITERS] = i_next_en;

    // one register stage per micro-rotation
    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_stage
        mhu_cordic_stage #(
            .ITER (g)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_v       (s_v[g]),
            .i_d       (s_d[g]),
            .i_next_en (s_en[g+1]),
            .o_en      (s_en[g]),
            .o_v       (s_v[g+1]),
            .o_d       (s_d[g+1])
        );
    end

    assign o_en = s_en[0];
    assign o_v  = s_v[CORDIC_ITERS];
    assign o_d  = s_d[CORDIC_ITERS];

endmodule

[src/mhu_back.sv]
module mhu_back import mhu_pkg::*; #(
    parameter int HEADING_FRAC_BITS = HFB_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_v,
    input  t_cordic                      i_d,
    output logic                         o_en,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [HEADING_FRAC_BITS+8:0] o_heading,
    output logic signed [15:0]           o_axis_x,
    output logic signed [15:0]           o_axis_y,
    output logic signed [15:0]           o_axis_z,
    output logic                         o_valid_res
);

    localparam int F     = HEADING_FRAC_BITS;
    localparam int PW    = 51;               // (z >> 16) * 45
    localparam int SUMW  = PW + F + 1;
    localparam int QW    = 7 + F;            // up to 90 degrees
    localparam int HW    = 9 + F;            // up to 360 degrees
    localparam logic [SUMW-1:0] RND    = SUMW'(1) << 43;
    localparam logic [QW-1:0]   QUAD90 = QW'(90 * (2 ** F));
    localparam logic [HW:0]     HALF   = (HW+1)'(180 * (2 ** F));
    localparam logic [HW:0]     FULL   = (HW+1)'(360 * (2 ** F));
    localparam logic signed [CORDIC_W-1:0] ZMAX = CORDIC_W'(1) << ZFRAC;

    // ---- stage M: clamp angle and scale to degrees ----
    logic [ZFRAC:0]  zc;
    logic [PW-1:0]   zs, n_m_prod;
    logic [PW-1:0]   r_m_prod;
    t_side           r_m_side;
    logic            r_m_v, en_m;

    always_comb begin
        if (i_d.z[CORDIC_W-1]) begin
            zc = '0;
        end else if (i_d.z > ZMAX) begin
            zc = ZMAX[ZFRAC:0];
        end else begin
            zc = i_d.z[ZFRAC:0];
        end
        zs       = PW'(zc[ZFRAC:16]);
        // times 45 as shift-add
        n_m_prod = (zs << 5) + (zs << 3) + (zs << 2) + zs;
    end

    // ---- stage R: round to code, unfold the octant ----
    logic [SUMW-1:0] sum;
    logic [QW-1:0]   code, n_r_quad;
    logic [QW-1:0]   r_r_quad;
    t_side           r_r_side;
    logic            r_r_v, en_r;

    always_comb begin
        sum      = {1'b0, r_m_prod, {F{1'b0}}} + RND;
        code     = sum[44 +: QW];
        n_r_quad = r_m_side.swap ? (QUAD90 - code) : code;
    end

    // ---- stage Q: quadrant, wrap, output register ----
    logic [HW:0]     hq, h;
    logic [HW-1:0]   n_q_heading;
    logic [HW-1:0]   r_q_heading;
    t_side           r_q_side;
    logic            r_q_v, en_q;

    always_comb begin
        hq = (HW+1)'(r_r_quad);
        priority if (!r_r_side.x_neg && !r_r_side.y_neg) begin
            h = hq;
        end else if (r_r_side.x_neg && !r_r_side.y_neg) begin
            h = HALF - hq;
        end else if (r_r_side.x_neg) begin
            h = HALF + hq;
        end else begin
            h = FULL - hq;
        end
        if (h >= FULL) begin
            h = h - FULL;
        end
        if (!r_r_side.ok_res || r_r_side.zero) begin
            n_q_heading = '0;
        end else begin
            n_q_heading = h[HW-1:0];
        end
    end

    // enables: a stage moves when empty or when its word is taken
    assign en_q = !r_q_v || !i_stall;
    assign en_r = !r_r_v || en_q;
    assign en_m = !r_m_v || en_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_r_v <= 1'b0;
            r_q_v <= 1'b0;
        end else begin
            if (en_m) r_m_v <= i_v;
            if (en_r) r_r_v <= r_m_v;
            if (en_q) r_q_v <= r_r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_m_prod <= n_m_prod;
            r_m_side <= i_d.side;
        end
        if (en_r) begin
            r_r_quad <= n_r_quad;
            r_r_side <= r_m_side;
        end
        if (en_q) begin
            r_q_heading <= n_q_heading;
            r_q_side    <= r_r_side;
        end
    end

    assign o_en        = en_m;
    assign o_valid     = r_q_v;
    assign o_heading   = r_q_heading;
    assign o_axis_x    = r_q_side.axis_x;
    assign o_axis_y    = r_q_side.axis_y;
    assign o_axis_z    = r_q_side.axis_z;
    assign o_valid_res = r_q_side.ok_res;

endmodule

[src/mhu_checker.sv]
module mhu_checker import mhu_pkg::*; #(
    parameter int HEADING_FRAC_BITS = HFB_DEFAULT
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_transfer_ok,
    input logic [7:0]                   i_x_high,
    input logic [7:0]                   i_x_low,
    input logic [7:0]                   i_z_high,
    input logic [7:0]                   i_z_low,
    input logic [7:0]                   i_y_high,
    input logic [7:0]                   i_y_low,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [HEADING_FRAC_BITS+8:0] o_heading,
    input logic signed [15:0]           o_axis_x,
    input logic signed [15:0]           o_axis_y,
    input logic signed [15:0]           o_axis_z,
    input logic                         o_valid_res
);

    localparam logic [HEADING_FRAC_BITS+8:0] FULL =
        (HEADING_FRAC_BITS+9)'(360 * (2 ** HEADING_FRAC_BITS));

    // output word held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_heading) && $stable(o_valid_res))
        else $error("output word changed under stall");

    // invalid results carry a zero heading
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_heading == '0)
        else $error("heading nonzero on invalid result");

    // heading stays below one full turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading < FULL)
        else $error("heading out of range");

    // a valid result never shows the overflow marker on any axis
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |->
            o_axis_x != OVF_MARK && o_axis_y != OVF_MARK && o_axis_z != OVF_MARK)
        else $error("valid result with overflowed axis");

    // pipeline empties on reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind magnetometer_heading_unit mhu_checker #(
    .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
) u_mhu_checker (.*);

[verif/magnetometer_heading_checker.sv]
// Watches both channels of the heading unit, predicts each result word from the
// accepted sample word and compares it field by field, oldest first.
module magnetometer_heading_checker import mhu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_word_valid,
    input  logic                   i_word_stall,
    input  logic                   i_transfer_ok,
    input  logic [7:0]             i_x_high,
    input  logic [7:0]             i_x_low,
    input  logic [7:0]             i_z_high,
    input  logic [7:0]             i_z_low,
    input  logic [7:0]             i_y_high,
    input  logic [7:0]             i_y_low,
    input  logic                   i_res_valid,
    input  logic                   i_res_stall,
    input  logic [HFB_DEFAULT+8:0] i_heading,
    input  logic signed [15:0]     i_axis_x,
    input  logic signed [15:0]     i_axis_y,
    input  logic signed [15:0]     i_axis_z,
    input  logic                   i_valid_res,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int FULL_TURN   = 360 << HFB_DEFAULT;
    localparam int RIGHT_ANGLE = 90 << HFB_DEFAULT;

    typedef struct packed {
        logic [HFB_DEFAULT+8:0] heading;
        logic signed [15:0]     axis_x;
        logic signed [15:0]     axis_y;
        logic signed [15:0]     axis_z;
        logic                   valid_res;
    } t_reading;

    // micro-rotation angles, Q60 in units of 45 degrees
    logic [63:0] rot_angle [CORDIC_ITERS];
    t_reading    expected_readings [$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // atan(1/n) in Q62, alternating series
    function automatic logic [63:0] arctan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] k;
        p   = (64'd1 << 62) / n;
        acc = '0;
        k   = '0;
        while (p != 0) begin
            term = p / (2 * k + 1);
            if (k[0]) acc = acc - term;
            else      acc = acc + term;
            p = p / (n * n);
            k = k + 1;
        end
        return acc;
    endfunction

    // atan(2^-i) in Q62, i >= 1
    function automatic logic [63:0] arctan_pow2(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        int          e;
        acc = '0;
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            e    = i * (2 * k + 1);
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            if (k % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        return acc;
    endfunction

    // angle table: atan(2^-i) divided by pi/4 (Machin), bit by bit
    initial begin : build_angles
        logic [63:0] quarter;
        logic [63:0] rem;
        logic [63:0] q;
        int          i;
        int          b;
        quarter      = 4 * arctan_recip(64'd5) - arctan_recip(64'd239);
        rot_angle[0] = 64'd1 << ZFRAC;
        for (i = 1; i < CORDIC_ITERS; i++) begin
            rem = arctan_pow2(i);
            q   = '0;
            for (b = 0; b < 62; b++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= quarter) begin
                    rem  = rem - quarter;
                    q[0] = 1'b1;
                end
            end
            rot_angle[i] = q >> 2;
        end
    end

    // rounded atan(num/den) in heading codes, 0 <= num <= den, den > 0
    function automatic int octant_angle(input int num, input int den);
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        logic [63:0] w;
        int          i;
        x = longint'(den) <<< PRESCALE;
        y = longint'(num) <<< PRESCALE;
        z = 0;
        for (i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(rot_angle[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(rot_angle[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(1) <<< ZFRAC)) z = longint'(1) <<< ZFRAC;
        w = z;
        w = ((w >> 16) * 64'd45) << HFB_DEFAULT;
        return int'((w + (64'd1 << 43)) >> 44);
    endfunction

    // expected result word for one sample word
    function automatic t_reading heading_of(input logic ok, input logic [7:0] xh,
                                            input logic [7:0] xl, input logic [7:0] zh,
                                            input logic [7:0] zl, input logic [7:0] yh,
                                            input logic [7:0] yl);
        t_reading           r;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        int                 ax;
        int                 ay;
        int                 quad;
        int                 h;
        r = '0;
        if (!ok) return r;
        x = {xh, xl};
        y = {yh, yl};
        z = {zh, zl};
        r.axis_x = x;
        r.axis_y = y;
        r.axis_z = z;
        // overflow marker on any axis: axes pass, heading 0, not valid
        if (x == OVF_MARK || y == OVF_MARK || z == OVF_MARK) return r;
        r.valid_res = 1'b1;
        if (x == 0 && y == 0) begin
            h = 0;
        end else begin
            ax = (x < 0) ? -int'(x) : int'(x);
            ay = (y < 0) ? -int'(y) : int'(y);
            if (ay <= ax) quad = octant_angle(ay, ax);
            else          quad = RIGHT_ANGLE - octant_angle(ax, ay);
            if (x >= 0 && y >= 0) h = quad;
            else if (x < 0 && y >= 0) h = FULL_TURN / 2 - quad;
            else if (x < 0) h = FULL_TURN / 2 + quad;
            else h = FULL_TURN - quad;
            // a heading that rounds to 360 wraps to 0
            if (h >= FULL_TURN) h = h - FULL_TURN;
            if (h < 0) h = h + FULL_TURN;
        end
        r.heading = h[HFB_DEFAULT+8:0];
        return r;
    endfunction

    function automatic void compare_field(input string what, input int want, input int got);
        if (want != got) begin
            if (fail_total < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_total++;
        end
    endfunction

    // score result words first, then queue the prediction for a new sample word
    always @(posedge i_clk) begin : score
        t_reading want;
        if (i_rst_n) begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_readings.size() == 0) begin
                    if (fail_total < MAX_REPORTS)
                        $display("%0t ns: result word with none expected, heading %0d",
                                 $time, i_heading);
                    fail_total++;
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("heading", int'(want.heading), int'(i_heading));
                    compare_field("axis_x", int'(want.axis_x), int'(i_axis_x));
                    compare_field("axis_y", int'(want.axis_y), int'(i_axis_y));
                    compare_field("axis_z", int'(want.axis_z), int'(i_axis_z));
                    compare_field("valid_res", int'(want.valid_res), int'(i_valid_res));
                end
            end
            if (i_word_valid && !i_word_stall)
                expected_readings.push_back(heading_of(i_transfer_ok, i_x_high, i_x_low,
                                                       i_z_high, i_z_low, i_y_high, i_y_low));
        end
        o_pending <= expected_readings.size();
    end

endmodule

[verif/tb_magnetometer_heading_unit.sv]
module tb_magnetometer_heading_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mhu_pkg::*;

    localparam int RANDOM_WORDS = 450;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 100;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   o_stall;
    logic                   i_transfer_ok = 1'b0;
    logic [7:0]             i_x_high      = '0;
    logic [7:0]             i_x_low       = '0;
    logic [7:0]             i_z_high      = '0;
    logic [7:0]             i_z_low       = '0;
    logic [7:0]             i_y_high      = '0;
    logic [7:0]             i_y_low       = '0;
    logic                   o_valid;
    logic                   i_stall       = 1'b0;
    logic [HFB_DEFAULT+8:0] o_heading;
    logic signed [15:0]     o_axis_x;
    logic signed [15:0]     o_axis_y;
    logic signed [15:0]     o_axis_z;
    logic                   o_valid_res;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    always #10 i_clk = ~i_clk;

    magnetometer_heading_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_transfer_ok(i_transfer_ok),
        .i_x_high     (i_x_high),
        .i_x_low      (i_x_low),
        .i_z_high     (i_z_high),
        .i_z_low      (i_z_low),
        .i_y_high     (i_y_high),
        .i_y_low      (i_y_low),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_heading    (o_heading),
        .o_axis_x     (o_axis_x),
        .o_axis_y     (o_axis_y),
        .o_axis_z     (o_axis_z),
        .o_valid_res  (o_valid_res)
    );

    magnetometer_heading_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (i_valid),
        .i_word_stall (o_stall),
        .i_transfer_ok(i_transfer_ok),
        .i_x_high     (i_x_high),
        .i_x_low      (i_x_low),
        .i_z_high     (i_z_high),
        .i_z_low      (i_z_low),
        .i_y_high     (i_y_high),
        .i_y_low      (i_y_low),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_heading    (o_heading),
        .i_axis_x     (o_axis_x),
        .i_axis_y     (o_axis_y),
        .i_axis_z     (o_axis_z),
        .i_valid_res  (o_valid_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side back-pressure, off during the calm stretch
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 29);
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one sample word after random idle cycles, hold it until taken
    task automatic send_sample(input logic ok, input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        if (!calm) begin
            while ($urandom_range(99) < 29) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_transfer_ok <= ok;
        i_x_high      <= x[15:8];
        i_x_low       <= x[7:0];
        i_y_high      <= y[15:8];
        i_y_low       <= y[7:0];
        i_z_high      <= z[15:8];
        i_z_low       <= z[7:0];
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin : stimulus
        int          n;
        int          sel;
        logic        ok;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // failed transfers
        send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(1'b0, 16'h1234, 16'hA5C3, 16'h5A3C);
        // overflow marker on each axis
        send_sample(1'b1, OVF_MARK, 16'd100, 16'd5);
        send_sample(1'b1, 16'd100, OVF_MARK, 16'd5);
        send_sample(1'b1, 16'd100, 16'd5, OVF_MARK);
        // near the marker but not on it
        send_sample(1'b1, 16'hF001, 16'hEFFF, 16'h1000);
        // both axes zero
        send_sample(1'b1, 16'd0, 16'd0, 16'd77);
        // on the axes: 180, 0, 90, 270
        send_sample(1'b1, -16'sd5, 16'd0, 16'd0);
        send_sample(1'b1, 16'd300, 16'd0, 16'd0);
        send_sample(1'b1, 16'h7FFF, 16'd0, 16'h7FFF);
        send_sample(1'b1, 16'h8000, 16'd0, 16'h8000);
        send_sample(1'b1, 16'd0, 16'h7FFF, 16'd0);
        send_sample(1'b1, 16'd0, 16'h8000, 16'd0);
        // extremes and diagonals
        send_sample(1'b1, 16'h8000, 16'h8000, 16'h7FFF);
        send_sample(1'b1, 16'h8000, 16'h7FFF, 16'h8000);
        send_sample(1'b1, 16'd100, 16'd100, 16'd1);
        send_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // fourth quadrant: just below 360 wraps to 0, and two that stay
        send_sample(1'b1, 16'h7FFF, -16'sd1, 16'd0);
        send_sample(1'b1, 16'd1000, -16'sd1, 16'd0);
        send_sample(1'b1, 16'd3, -16'sd7, 16'd0);

        // random samples, middle stretch with no idling on either side
        for (n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 150 && n < 250);
            sel  = $urandom_range(99);
            ok   = 1'b1;
            x    = $urandom;
            y    = $urandom;
            z    = $urandom;
            if (sel < 10) begin
                ok = 1'b0;
            end else if (sel < 18) begin
                case ($urandom_range(2))
                    0:       x = OVF_MARK;
                    1:       y = OVF_MARK;
                    default: z = OVF_MARK;
                endcase
            end else if (sel < 30) begin
                x = 16'($urandom_range(16)) - 16'd8;
                y = 16'($urandom_range(16)) - 16'd8;
            end else if (sel < 36) begin
                if ($urandom_range(1) == 0) x = '0;
                else                        y = '0;
            end
            send_sample(ok, x, y, z);
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/mhu_pkg.sv
src/mhu_front.sv
src/mhu_cordic_stage.sv
src/mhu_cordic.sv
src/mhu_back.sv
src/magnetometer_heading_unit.sv
src/mhu_checker.sv
verif/magnetometer_heading_checker.sv
verif/tb_magnetometer_heading_unit.sv
